// File: src/dcfb_pkg.sv
// Package for the drive command frame builder: frame byte constants, direction
// codes, byte positions and the CRC-16/MODBUS helper functions and tables.
// No dependencies.
`default_nettype none

package dcfb_pkg;

  // Fixed frame bytes and reset speed
  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] CMD_BYTE    = 8'h07;
  localparam logic [7:0] PAD_BYTE    = 8'h00;
  localparam logic [7:0] SPEED_RESET = 8'd120;

  // Direction flag patterns
  localparam logic [7:0] FLAGS_FWD   = 8'h50;
  localparam logic [7:0] FLAGS_LEFT  = 8'h10;
  localparam logic [7:0] FLAGS_RIGHT = 8'h40;
  localparam logic [7:0] FLAGS_NONE  = 8'h00;

  // Direction codes
  localparam logic [3:0] DIR_FWD        = 4'd1;
  localparam logic [3:0] DIR_LEFT       = 4'd2;
  localparam logic [3:0] DIR_RIGHT      = 4'd3;
  localparam logic [3:0] DIR_BACK       = 4'd4;
  localparam logic [3:0] DIR_UP_LEFT    = 4'd6;
  localparam logic [3:0] DIR_DOWN_LEFT  = 4'd7;
  localparam logic [3:0] DIR_UP_RIGHT   = 4'd8;
  localparam logic [3:0] DIR_DOWN_RIGHT = 4'd9;

  // Byte positions within a frame
  typedef logic [3:0] byte_idx_t;
  localparam byte_idx_t IDX_SYNC   = 4'd0;
  localparam byte_idx_t IDX_CMD    = 4'd1;
  localparam byte_idx_t IDX_LEFT   = 4'd2;
  localparam byte_idx_t IDX_PAD_L  = 4'd3;
  localparam byte_idx_t IDX_RIGHT  = 4'd4;
  localparam byte_idx_t IDX_PAD_R  = 4'd5;
  localparam byte_idx_t IDX_FLAGS  = 4'd6;
  localparam byte_idx_t IDX_CRC_LO = 4'd7;
  localparam byte_idx_t IDX_CRC_HI = 4'd8;

  // CRC-16/MODBUS
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One column per data bit: the 16-bit image of that bit after the CRC shifts
  typedef logic [7:0][15:0] crc_cols_t;

  // Shift the CRC register by nbits with zero data (elaboration use only)
  function automatic logic [15:0] crc_shift(input logic [15:0] crc, input int unsigned nbits);
    logic [15:0] c;
    c = crc;
    for (int unsigned i = 0; i < nbits; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Byte update of the CRC register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    return crc_shift(crc ^ {8'h00, d}, 8);
  endfunction

  // Columns of the linear map from a data byte to its CRC contribution
  function automatic crc_cols_t crc_columns(input int unsigned nbits);
    crc_cols_t cols;
    for (int i = 0; i < 8; i++) begin
      cols[i] = crc_shift(16'(1) << i, nbits);
    end
    return cols;
  endfunction

  // CRC of the frame with all variable bytes zero
  localparam logic [15:0] CRC_BASE =
    crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, CMD_BYTE),
      PAD_BYTE), PAD_BYTE), PAD_BYTE), PAD_BYTE), PAD_BYTE);

  // Left byte is followed by four bytes, right by two, flags by none
  localparam crc_cols_t COLS_LEFT  = crc_columns(40);
  localparam crc_cols_t COLS_RIGHT = crc_columns(24);
  localparam crc_cols_t COLS_FLAGS = crc_columns(8);

  // XOR of the columns selected by the data bits
  function automatic logic [15:0] crc_contrib(input crc_cols_t cols, input logic [7:0] d);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (d[i]) acc = acc ^ cols[i];
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: src/dcfb_if.sv
// Valid/ready channel interfaces of the drive command frame builder:
// direction command, frame byte stream and speed register write.
// No dependencies.
`default_nettype none

interface dcfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] direction;
  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

interface dcfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface dcfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] wheel_speed;
  modport source (output valid, output wheel_speed, input ready);
  modport sink (input valid, input wheel_speed, output ready);
endinterface

`default_nettype wire

// File: src/drive_command_frame_builder_unit.sv
// Top level of the drive command frame builder: command register, frame
// decode with CRC, frame register and byte serializer.
// Depends on dcfb_pkg and the interfaces in dcfb_if.sv.
`default_nettype none

// Each accepted direction command produces one 9-byte motor command frame
// (FF 07 left 00 right 00 flags crc_lo crc_hi), one byte per out_ch transfer,
// with last_byte set on the CRC high byte. A command passes through the
// command register and then the frame register before its first byte is
// offered; one further command is buffered while a frame drains. The speed
// register (reset 120) is written through cfg_ch and always ready; write it
// only while no frame is pending.
module drive_command_frame_builder_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dcfb_cmd_if.sink   in_ch,
  dcfb_byte_if.source out_ch,
  dcfb_cfg_if.sink   cfg_ch
);
  import dcfb_pkg::*;

  logic        cfg_xfer;
  logic [7:0]  speed_r;
  logic        s1_vld_r;
  logic [3:0]  s1_dir_r;
  logic        frm_vld_r;
  logic [7:0]  left_r, right_r, flags_r;
  logic [15:0] crc_r;
  byte_idx_t   idx_r;

  logic [7:0]  left_nxt, right_nxt, flags_nxt;
  logic [15:0] crc_nxt;
  logic        in_xfer, out_xfer, out_last, frm_free, s1_adv;

  // Handshake control
  assign out_last  = (idx_r == IDX_CRC_HI);
  assign out_xfer  = frm_vld_r & out_ch.ready;
  assign frm_free  = !frm_vld_r | (out_xfer & out_last);
  assign s1_adv    = s1_vld_r & frm_free;
  assign in_ch.ready = !s1_vld_r | frm_free;
  assign in_xfer   = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer  = cfg_ch.valid;

  // Direction decode
  always_comb begin
    left_nxt  = 8'h00;
    right_nxt = 8'h00;
    flags_nxt = FLAGS_NONE;
    unique case (s1_dir_r)
      DIR_FWD: begin
        left_nxt = speed_r; right_nxt = speed_r; flags_nxt = FLAGS_FWD;
      end
      DIR_LEFT: begin
        left_nxt = speed_r; right_nxt = speed_r; flags_nxt = FLAGS_LEFT;
      end
      DIR_RIGHT: begin
        left_nxt = speed_r; right_nxt = speed_r; flags_nxt = FLAGS_RIGHT;
      end
      DIR_BACK: begin
        left_nxt = speed_r; right_nxt = speed_r;
      end
      DIR_UP_LEFT: begin
        right_nxt = speed_r; flags_nxt = FLAGS_FWD;
      end
      DIR_DOWN_LEFT: begin
        right_nxt = speed_r;
      end
      DIR_UP_RIGHT: begin
        left_nxt = speed_r; flags_nxt = FLAGS_FWD;
      end
      DIR_DOWN_RIGHT: begin
        left_nxt = speed_r;
      end
      default: begin
        // stop and unknown codes: zero speeds and flags
        left_nxt = 8'h00;
      end
    endcase
  end

  // CRC is affine in the variable bytes: base plus one linear term per byte
  assign crc_nxt = CRC_BASE ^ crc_contrib(COLS_LEFT, left_nxt)
                 ^ crc_contrib(COLS_RIGHT, right_nxt)
                 ^ crc_contrib(COLS_FLAGS, flags_nxt);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= SPEED_RESET;
      s1_vld_r  <= 1'b0;
      frm_vld_r <= 1'b0;
      idx_r     <= IDX_SYNC;
    end else begin
      if (cfg_xfer) speed_r <= cfg_ch.wheel_speed;
      s1_vld_r <= in_xfer | (s1_vld_r & !s1_adv);
      if (s1_adv) frm_vld_r <= 1'b1;
      else if (frm_free) frm_vld_r <= 1'b0;
      if (out_xfer) idx_r <= out_last ? IDX_SYNC : idx_r + 4'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) s1_dir_r <= in_ch.direction;
    if (s1_adv) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      flags_r <= flags_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Byte select
  always_comb begin
    unique case (idx_r)
      IDX_SYNC:   out_ch.frame_byte = SYNC_BYTE;
      IDX_CMD:    out_ch.frame_byte = CMD_BYTE;
      IDX_LEFT:   out_ch.frame_byte = left_r;
      IDX_PAD_L:  out_ch.frame_byte = PAD_BYTE;
      IDX_RIGHT:  out_ch.frame_byte = right_r;
      IDX_PAD_R:  out_ch.frame_byte = PAD_BYTE;
      IDX_FLAGS:  out_ch.frame_byte = flags_r;
      IDX_CRC_LO: out_ch.frame_byte = crc_r[7:0];
      IDX_CRC_HI: out_ch.frame_byte = crc_r[15:8];
      default:    out_ch.frame_byte = PAD_BYTE;
    endcase
  end

  assign out_ch.valid     = frm_vld_r;
  assign out_ch.last_byte = out_last;

`ifndef ASSERT_OFF
  // Byte counter never leaves the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_CRC_HI) else $error("byte index past end of frame");

  // Counter steps by one on each non-final byte transfer
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last |=> idx_r == $past(idx_r) + 4'd1 && frm_vld_r)
    else $error("byte index did not advance");

  // Counter wraps after the CRC high byte
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_last |=> idx_r == IDX_SYNC)
    else $error("byte index did not wrap");

  // Stalling the input means a command is already buffered
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_vld_r && frm_vld_r)
    else $error("input stalled with free buffer");

  // Frame only reloads when the previous one is done
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    frm_vld_r && !(out_xfer && out_last) |=> idx_r != IDX_SYNC || $past(idx_r) == IDX_SYNC)
    else $error("frame register overwritten mid-frame");
`endif

endmodule

`default_nettype wire
